// ----- src/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Types, widths and codes shared by the scanned ADC channel monitor.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int CHAN_W     = 3;
  localparam int QUERY_W    = 3;
  localparam int READ_W     = 11;
  localparam int BAND_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int LAST_CHANNEL  = 7;
  localparam int NUM_CH        = LAST_CHANNEL + 1;
  localparam int SAMPLE_LEVELS = 1024;
  localparam int MID_CODE      = SAMPLE_LEVELS / 2 - 1;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [READ_W-1:0]     read_t;
  typedef logic [BAND_W-1:0]     band_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam sample_t MID_VALUE  = sample_t'(MID_CODE);
  localparam read_t   MIN_RESET  = read_t'(SAMPLE_LEVELS);
  localparam chan_t   LAST_CHAN  = chan_t'(LAST_CHANNEL);

  localparam sample_t PEAK_HIGH_RST  = 10'd1014;
  localparam sample_t PEAK_LOW_RST   = 10'd10;
  localparam sample_t ZERO_CENTER_RST = 10'd511;
  localparam band_t   ZERO_BAND_RST  = 9'd30;
  localparam chan_t   FIRST_CHAN_RST = 3'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [QUERY_W-1:0] {
    Q_VALUE = 3'd0,
    Q_DONE  = 3'd1,
    Q_ZERO  = 3'd2,
    Q_TRIP  = 3'd3,
    Q_MAX   = 3'd4,
    Q_MIN   = 3'd5
  } query_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_HIGH   = 3'd0,
    CFG_PEAK_LOW    = 3'd1,
    CFG_ZERO_CENTER = 3'd2,
    CFG_ZERO_BAND   = 3'd3,
    CFG_FIRST_CHAN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic    en;
    kind_t   kind;
    sample_t sample;
    chan_t   chan;
    query_t  query;
  } req_t;

  typedef struct packed {
    sample_t peak_high;
    sample_t peak_low;
    sample_t zero_center;
    band_t   zero_band;
  } thresh_t;

endpackage

// ----- src/scm_in_if.sv -----
// ----------------------------------------------------------------------------
// scm_in_if
// Input item channel: sample, read query or channel reset.
// ----------------------------------------------------------------------------
interface scm_in_if;
  import scm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]   channel;
  logic [QUERY_W-1:0]  query;

  modport source (output valid, kind, sample, channel, query, input ready);
  modport sink (input valid, kind, sample, channel, query, output ready);
endinterface

// ----- src/scm_out_if.sv -----
// ----------------------------------------------------------------------------
// scm_out_if
// Result item channel: read data and next scan channel.
// ----------------------------------------------------------------------------
interface scm_out_if;
  import scm_pkg::*;

  logic              valid;
  logic              ready;
  logic [READ_W-1:0] read_data;
  logic [CHAN_W-1:0] next_channel;

  modport source (output valid, read_data, next_channel, input ready);
  modport sink (input valid, read_data, next_channel, output ready);
endinterface

// ----- src/scm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// scm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scm_cfg_if;
  import scm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/scanned_adc_channel_monitor.sv -----
// ----------------------------------------------------------------------------
// scanned_adc_channel_monitor
// Round-robin scan of ADC channels with per-channel stats and read-and-clear.
// ----------------------------------------------------------------------------
// An accepted item's result is registered in the output register, valid in the following cycle.
// Throughput: one item per cycle while the output is not stalled; the record update is a single compare pass.
// Input is taken whenever the output register is empty or being drained.
// Reset: synchronous; all channels back to defaults, registers to reset values,
// scan at the reset first channel, output register empty.
module scanned_adc_channel_monitor (
  input logic      clk,
  input logic      rst,
  scm_in_if.sink   items,
  scm_out_if.source results,
  scm_cfg_if.sink  cfg
);
  import scm_pkg::*;

  thresh_t thresh;
  chan_t   first_channel;
  chan_t   scan_channel;
  chan_t   scan_next;
  logic    accept;
  req_t    req;
  read_t   bank_data;
  logic    out_valid;
  read_t   read_data;
  chan_t   next_channel;

  assign cfg.ready   = 1'b1;
  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.peak_high   <= PEAK_HIGH_RST;
      thresh.peak_low    <= PEAK_LOW_RST;
      thresh.zero_center <= ZERO_CENTER_RST;
      thresh.zero_band   <= ZERO_BAND_RST;
      first_channel      <= FIRST_CHAN_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_PEAK_HIGH:   thresh.peak_high   <= cfg.data[SAMPLE_W-1:0];
        CFG_PEAK_LOW:    thresh.peak_low    <= cfg.data[SAMPLE_W-1:0];
        CFG_ZERO_CENTER: thresh.zero_center <= cfg.data[SAMPLE_W-1:0];
        CFG_ZERO_BAND:   thresh.zero_band   <= cfg.data[BAND_W-1:0];
        CFG_FIRST_CHAN:  first_channel      <= cfg.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    req.en     = accept;
    req.kind   = kind_t'(items.kind);
    req.sample = items.sample;
    req.query  = query_t'(items.query);
    req.chan   = (req.kind == KIND_SAMPLE) ? scan_channel : items.channel;
    scan_next  = (scan_channel >= LAST_CHAN) ? first_channel : scan_channel + 1'b1;
  end

  scm_chan_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .thresh    (thresh),
    .read_data (bank_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_channel <= FIRST_CHAN_RST;
      out_valid    <= 1'b0;
    end else begin
      if (accept && req.kind == KIND_SAMPLE) scan_channel <= scan_next;
      if (accept) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data    <= bank_data;
      next_channel <= (req.kind == KIND_SAMPLE) ? scan_next : scan_channel;
    end
  end

  assign results.valid        = out_valid;
  assign results.read_data    = read_data;
  assign results.next_channel = next_channel;

endmodule

// ----- src/scm_chan_bank.sv -----
// ----------------------------------------------------------------------------
// scm_chan_bank
// Per-channel records: last value, max, min, done, peak trip and zero flags.
// ----------------------------------------------------------------------------
module scm_chan_bank (
  input  logic             clk,
  input  logic             rst,
  input  scm_pkg::req_t    req,
  input  scm_pkg::thresh_t thresh,
  output scm_pkg::read_t   read_data
);
  import scm_pkg::*;

  sample_t           last_value [NUM_CH];
  sample_t           max_value  [NUM_CH];
  read_t             min_value  [NUM_CH];
  logic [NUM_CH-1:0] done_flag;
  logic [NUM_CH-1:0] trip_flag;
  logic [NUM_CH-1:0] zero_flag;

  logic signed [SAMPLE_W+1:0] zero_lo;
  logic signed [SAMPLE_W+1:0] zero_hi;
  logic signed [SAMPLE_W+1:0] sample_s;
  logic                       in_zero;
  logic                       trip;

  always_comb begin
    zero_lo  = $signed({2'b00, thresh.zero_center}) - $signed({3'b000, thresh.zero_band});
    zero_hi  = $signed({2'b00, thresh.zero_center}) + $signed({3'b000, thresh.zero_band});
    sample_s = $signed({2'b00, req.sample});
    in_zero  = (sample_s > zero_lo) && (sample_s < zero_hi);
    trip     = (req.sample > thresh.peak_high) || (req.sample < thresh.peak_low);
  end

  always_comb begin
    read_data = '0;
    if (req.kind == KIND_READ) begin
      case (req.query)
        Q_VALUE: read_data = {1'b0, last_value[req.chan]};
        Q_DONE:  read_data = read_t'(done_flag[req.chan]);
        Q_ZERO:  read_data = read_t'(zero_flag[req.chan]);
        Q_TRIP:  read_data = read_t'(trip_flag[req.chan]);
        Q_MAX:   read_data = {1'b0, max_value[req.chan]};
        Q_MIN:   read_data = min_value[req.chan];
        default: read_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        last_value[i] <= MID_VALUE;
        max_value[i]  <= '0;
        min_value[i]  <= MIN_RESET;
      end
      done_flag <= '0;
      trip_flag <= '0;
      zero_flag <= '1;
    end else if (req.en) begin
      case (req.kind)
        KIND_SAMPLE: begin
          last_value[req.chan] <= req.sample;
          if (max_value[req.chan] < req.sample) max_value[req.chan] <= req.sample;
          if (min_value[req.chan] > {1'b0, req.sample}) begin
            min_value[req.chan] <= {1'b0, req.sample};
          end
          done_flag[req.chan] <= 1'b1;
          if (trip) trip_flag[req.chan] <= 1'b1;
          zero_flag[req.chan] <= in_zero;
        end
        KIND_READ: begin
          case (req.query)
            Q_VALUE: done_flag[req.chan] <= 1'b0;
            Q_TRIP:  trip_flag[req.chan] <= 1'b0;
            Q_MAX:   max_value[req.chan] <= '0;
            Q_MIN:   min_value[req.chan] <= MIN_RESET;
            default: ;
          endcase
        end
        KIND_CLEAR: begin
          last_value[req.chan] <= MID_VALUE;
          max_value[req.chan]  <= '0;
          min_value[req.chan]  <= MIN_RESET;
          done_flag[req.chan]  <= 1'b0;
          trip_flag[req.chan]  <= 1'b0;
          zero_flag[req.chan]  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives sample, read and channel reset items into the channel monitor under
// random idling and output stalls, across several threshold and scan settings.
// Keeps its own copy of every channel record and checks each readout in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scm_pkg::*;

  localparam logic [KIND_W-1:0]  KIND_BAD   = 2'd3;
  localparam logic [QUERY_W-1:0] Q_BAD_LO   = 3'd6;
  localparam logic [QUERY_W-1:0] Q_BAD_HI   = 3'd7;
  localparam int                 IDLE_PCT   = 30;
  localparam int                 LONG_HOLD  = 200;

  typedef struct {
    read_t data;
    chan_t next_ch;
  } readout_t;

  logic clk;
  logic rst;

  scm_in_if  items_if ();
  scm_out_if results_if ();
  scm_cfg_if cfg_if ();

  scanned_adc_channel_monitor i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // monitor state as predicted
  sample_t cur_peak_high;
  sample_t cur_peak_low;
  sample_t cur_zero_center;
  band_t   cur_zero_band;
  chan_t   cur_first_chan;
  int      scan_pos;
  sample_t last_code [NUM_CH];
  sample_t max_code  [NUM_CH];
  read_t   min_code  [NUM_CH];
  bit      done_bit  [NUM_CH];
  bit      trip_bit  [NUM_CH];
  bit      zero_bit  [NUM_CH];

  readout_t awaited_readouts[$];
  int       mismatch_count = 0;
  bit       idle_on = 1'b1;
  int       hold_cycles = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_record(int c);
    last_code[c] = MID_VALUE;
    max_code[c]  = '0;
    min_code[c]  = MIN_RESET;
    done_bit[c]  = 1'b0;
    trip_bit[c]  = 1'b0;
    zero_bit[c]  = 1'b1;
  endfunction

  function automatic void reset_monitor();
    cur_peak_high   = PEAK_HIGH_RST;
    cur_peak_low    = PEAK_LOW_RST;
    cur_zero_center = ZERO_CENTER_RST;
    cur_zero_band   = ZERO_BAND_RST;
    cur_first_chan  = FIRST_CHAN_RST;
    scan_pos        = int'(FIRST_CHAN_RST);
    for (int c = 0; c < NUM_CH; c++) clear_record(c);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, cfg_data_t val);
    case (idx)
      CFG_PEAK_HIGH:   cur_peak_high   = val;
      CFG_PEAK_LOW:    cur_peak_low    = val;
      CFG_ZERO_CENTER: cur_zero_center = val;
      CFG_ZERO_BAND:   cur_zero_band   = band_t'(val);
      CFG_FIRST_CHAN:  cur_first_chan  = chan_t'(val);
      default: ;
    endcase
  endfunction

  function automatic readout_t update_monitor(logic [KIND_W-1:0] kind_code, sample_t code,
                                              chan_t ch, logic [QUERY_W-1:0] q);
    readout_t r;
    int       lo;
    int       hi;
    int       c;
    r.data = '0;
    case (kind_code)
      KIND_SAMPLE: begin
        c = scan_pos;
        if (c <= LAST_CHANNEL) begin
          lo = int'(cur_zero_center) - int'(cur_zero_band);
          hi = int'(cur_zero_center) + int'(cur_zero_band);
          last_code[c] = code;
          if (max_code[c] < code) max_code[c] = code;
          if (min_code[c] > read_t'(code)) min_code[c] = read_t'(code);
          done_bit[c] = 1'b1;
          if (code > cur_peak_high || code < cur_peak_low) trip_bit[c] = 1'b1;
          zero_bit[c] = (int'(code) > lo) && (int'(code) < hi);
        end
        c = c + 1;
        if (c > LAST_CHANNEL) c = int'(cur_first_chan);
        scan_pos = c;
      end
      KIND_READ: begin
        if (ch <= LAST_CHAN) begin
          case (q)
            Q_VALUE: begin
              r.data = read_t'(last_code[ch]);
              done_bit[ch] = 1'b0;
            end
            Q_DONE: r.data = read_t'(done_bit[ch]);
            Q_ZERO: r.data = read_t'(zero_bit[ch]);
            Q_TRIP: begin
              r.data = read_t'(trip_bit[ch]);
              trip_bit[ch] = 1'b0;
            end
            Q_MAX: begin
              r.data = read_t'(max_code[ch]);
              max_code[ch] = '0;
            end
            Q_MIN: begin
              r.data = min_code[ch];
              min_code[ch] = MIN_RESET;
            end
            default: r.data = '0;
          endcase
        end
      end
      KIND_CLEAR: begin
        if (ch <= LAST_CHAN) clear_record(int'(ch));
      end
      default: ;
    endcase
    r.next_ch = chan_t'(scan_pos);
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // result side: checks every accepted readout against the oldest prediction
  always @(posedge clk) begin
    readout_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (awaited_readouts.size() == 0) begin
        note_mismatch("unexpected item", -1, int'(results_if.read_data));
      end else begin
        want = awaited_readouts.pop_front();
        if (results_if.read_data !== want.data)
          note_mismatch("read_data", int'(want.data), int'(results_if.read_data));
        if (results_if.next_channel !== want.next_ch)
          note_mismatch("next_channel", int'(want.next_ch), int'(results_if.next_channel));
      end
    end
  end

  initial begin : result_sink
    int n;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        repeat (n) begin
          results_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      results_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind_code, sample_t code, chan_t ch,
                           logic [QUERY_W-1:0] q);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.kind    <= kind_code;
    items_if.sample  <= code;
    items_if.channel <= ch;
    items_if.query   <= q;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    awaited_readouts.push_back(update_monitor(kind_code, code, ch, q));
  endtask

  task automatic settle();
    items_if.valid <= 1'b0;
    while (awaited_readouts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_data_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    apply_register(idx, val);
  endtask

  task automatic set_thresholds(sample_t hi, sample_t lo, sample_t center, band_t band,
                                chan_t first);
    settle();
    write_reg(CFG_PEAK_HIGH, hi);
    write_reg(CFG_PEAK_LOW, lo);
    write_reg(CFG_ZERO_CENTER, center);
    write_reg(CFG_ZERO_BAND, cfg_data_t'(band));
    write_reg(CFG_FIRST_CHAN, cfg_data_t'(first));
    cfg_if.valid <= 1'b0;
  endtask

  // half uniform codes, half at or near the trip and window edges
  function automatic sample_t pick_sample();
    case ($urandom_range(11))
      0: return cur_peak_high;
      1: return sample_t'(cur_peak_high + 1);
      2: return cur_peak_low;
      3: return sample_t'(cur_peak_low - 1);
      4: return sample_t'(cur_zero_center - cur_zero_band + $urandom_range(2));
      5: return sample_t'(cur_zero_center + cur_zero_band - $urandom_range(2));
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic send_random(int count);
    logic [KIND_W-1:0]  kind_code;
    logic [QUERY_W-1:0] q;
    int                 roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 50) kind_code = KIND_SAMPLE;
      else if (roll < 88) kind_code = KIND_READ;
      else if (roll < 97) kind_code = KIND_CLEAR;
      else kind_code = KIND_BAD;
      if ($urandom_range(9) == 0) q = QUERY_W'($urandom_range(Q_BAD_HI, Q_BAD_LO));
      else q = QUERY_W'($urandom_range(Q_MIN, Q_VALUE));
      send_item(kind_code, pick_sample(), chan_t'($urandom()), q);
    end
  endtask

  task automatic test_defaults();
    for (int q = Q_VALUE; q <= Q_MIN; q++) send_item(KIND_READ, '0, chan_t'(0), 3'(q));
    send_item(KIND_READ, '0, chan_t'(1), Q_BAD_HI);
    send_item(KIND_BAD, '1, '1, '1);
  endtask

  task automatic test_extremes();
    // scan starts at the reset first channel and wraps after the last one
    send_item(KIND_SAMPLE, 10'd0, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd1023, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd10, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd9, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd1014, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd1015, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd481, '0, Q_VALUE);
    send_item(KIND_SAMPLE, 10'd482, '0, Q_VALUE);
    // read-and-clear: repeated max and trip reads, and a done read after a value read, show the cleared value
    send_item(KIND_READ, '0, chan_t'(3), Q_MAX);
    send_item(KIND_READ, '0, chan_t'(3), Q_MAX);
    send_item(KIND_READ, '0, chan_t'(3), Q_MIN);
    send_item(KIND_READ, '0, chan_t'(3), Q_TRIP);
    send_item(KIND_READ, '0, chan_t'(3), Q_TRIP);
    send_item(KIND_READ, '0, chan_t'(5), Q_ZERO);
    send_item(KIND_READ, '0, chan_t'(4), Q_VALUE);
    send_item(KIND_READ, '0, chan_t'(4), Q_DONE);
    send_item(KIND_CLEAR, '0, chan_t'(6), Q_VALUE);
    send_item(KIND_READ, '0, chan_t'(6), Q_MIN);
  endtask

  task automatic test_config_settings();
    set_thresholds(10'd0, 10'd1023, 10'd0, 9'd511, chan_t'(7));
    send_random(110);
    set_thresholds(10'd1023, 10'd0, 10'd1023, 9'd0, chan_t'(0));
    send_random(110);
    set_thresholds(10'd1023, 10'd0, 10'd1023, 9'd511, chan_t'(5));
    send_random(110);
    set_thresholds(sample_t'($urandom()), sample_t'($urandom()), sample_t'($urandom()),
                   band_t'($urandom()), chan_t'($urandom()));
    // indexes past the register list are ignored
    for (int k = 1; k <= 3; k++) write_reg(CFG_FIRST_CHAN + 3'(k), cfg_data_t'($urandom()));
    cfg_if.valid <= 1'b0;
    send_random(110);
    set_thresholds(PEAK_HIGH_RST, PEAK_LOW_RST, ZERO_CENTER_RST, ZERO_BAND_RST, FIRST_CHAN_RST);
    send_random(110);
  endtask

  task automatic test_backpressure();
    hold_cycles = LONG_HOLD;
    send_random(60);
  endtask

  task automatic test_random();
    send_random(300);
    idle_on = 1'b0;
    send_random(100);
    idle_on = 1'b1;
    send_random(100);
  endtask

  initial begin
    rst              <= 1'b1;
    items_if.valid   <= 1'b0;
    items_if.kind    <= KIND_SAMPLE;
    items_if.sample  <= '0;
    items_if.channel <= '0;
    items_if.query   <= Q_VALUE;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_PEAK_HIGH;
    cfg_if.data      <= '0;
    reset_monitor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_extremes();
    test_config_settings();
    test_backpressure();
    test_random();

    items_if.valid <= 1'b0;
    while (awaited_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
